>>> design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and action slots shared by the I2C master sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Input item kind, carried on s_tuser
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_EVENT = 2'd2,
        MODE_ERROR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_RX    = 2'd1,
        ST_TX    = 2'd2
    } xfer_state_t;

    typedef enum logic [4:0] {
        A_START     = 5'd0,
        A_BUSY      = 5'd1,
        A_ADDR      = 5'd2,
        A_CLRADDR   = 5'd3,
        A_ACKOFF    = 5'd4,
        A_WR        = 5'd5,
        A_RD        = 5'd6,
        A_STOP      = 5'd7,
        A_TXDONE    = 5'd8,
        A_RXDONE    = 5'd9,
        A_STOPF     = 5'd10,
        A_REQ       = 5'd11,
        A_RCV       = 5'd12,
        A_ACKON     = 5'd13,
        A_ERR_BUS   = 5'd14,
        A_ERR_ARLO  = 5'd15,
        A_ERR_AF    = 5'd16,
        A_ERR_OVR   = 5'd17,
        A_ERR_TMO   = 5'd18
    } action_t;

    // Action slots in emission order; one mask bit per slot
    localparam int NUM_SLOTS = 21;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int NUM_ERR   = 5;

    localparam logic [SLOT_W-1:0] SL_START    = 5'd0;
    localparam logic [SLOT_W-1:0] SL_BUSY     = 5'd1;
    localparam logic [SLOT_W-1:0] SL_ADDR     = 5'd2;
    localparam logic [SLOT_W-1:0] SL_ACKOFF_A = 5'd3;
    localparam logic [SLOT_W-1:0] SL_CLRADDR  = 5'd4;
    localparam logic [SLOT_W-1:0] SL_STOP_T   = 5'd5;
    localparam logic [SLOT_W-1:0] SL_TXDONE   = 5'd6;
    localparam logic [SLOT_W-1:0] SL_STOPF    = 5'd7;
    localparam logic [SLOT_W-1:0] SL_WR       = 5'd8;
    localparam logic [SLOT_W-1:0] SL_REQ      = 5'd9;
    localparam logic [SLOT_W-1:0] SL_ACKOFF_R = 5'd10;
    localparam logic [SLOT_W-1:0] SL_RD       = 5'd11;
    localparam logic [SLOT_W-1:0] SL_STOP_R   = 5'd12;
    localparam logic [SLOT_W-1:0] SL_ACKON    = 5'd13;
    localparam logic [SLOT_W-1:0] SL_RXDONE   = 5'd14;
    localparam logic [SLOT_W-1:0] SL_RCV      = 5'd15;
    localparam logic [SLOT_W-1:0] SL_ERR0     = 5'd16;
    localparam logic [SLOT_W-1:0] SL_ERR1     = 5'd17;
    localparam logic [SLOT_W-1:0] SL_ERR2     = 5'd18;
    localparam logic [SLOT_W-1:0] SL_ERR3     = 5'd19;
    localparam logic [SLOT_W-1:0] SL_ERR4     = 5'd20;

    // One classified input item: which slots fire, plus their data
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           addr_byte;  // address byte, or prior state
        logic [7:0]           tx_byte;
        logic [7:0]           rx_byte;
    } plan_t;

    function automatic action_t slot_action(input logic [SLOT_W-1:0] slot);
        case (slot)
            SL_START:    return A_START;
            SL_BUSY:     return A_BUSY;
            SL_ADDR:     return A_ADDR;
            SL_ACKOFF_A: return A_ACKOFF;
            SL_CLRADDR:  return A_CLRADDR;
            SL_STOP_T:   return A_STOP;
            SL_TXDONE:   return A_TXDONE;
            SL_STOPF:    return A_STOPF;
            SL_WR:       return A_WR;
            SL_REQ:      return A_REQ;
            SL_ACKOFF_R: return A_ACKOFF;
            SL_RD:       return A_RD;
            SL_STOP_R:   return A_STOP;
            SL_ACKON:    return A_ACKON;
            SL_RXDONE:   return A_RXDONE;
            SL_RCV:      return A_RCV;
            SL_ERR0:     return A_ERR_BUS;
            SL_ERR1:     return A_ERR_ARLO;
            SL_ERR2:     return A_ERR_AF;
            SL_ERR3:     return A_ERR_OVR;
            SL_ERR4:     return A_ERR_TMO;
            default:     return A_START;
        endcase
    endfunction

endpackage

>>> design/i2c_master_interrupt_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_interrupt_sequencer
// Interrupt-driven I2C master transfer sequencer: start requests, event and
// error items in, a run of driver actions out.
//
//   channel  dir  signals                         contents
//   s_       in   s_tvalid/s_tready/s_tdata/user  request, event or error item
//   m_       out  m_tvalid/m_tready/m_tdata/user  one action beat, tlast ends run
//   cfg_     in   cfg_valid/cfg_ready/cfg_data    ack_control register
//
// An item is classified in the cycle it is accepted; s_tready stays high
// while the plan queue has room, so items may arrive every cycle.
// The output stage emits one action per cycle unless m_ stalls: an item
// yielding N actions takes N beats (up to 8); items with none take no beat.
// Reset clears the transfer state and the queue and sets ack_control to 1.
// A stalled m_ side holds its beat and back-pressures s_ only once the
// queue fills.
// ----------------------------------------------------------------------------
module i2c_master_interrupt_sequencer
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // target_address[6:0], transfer_length[14:7], repeated_start[15],
    // status_flags[23:16], error_flags[28:24], tx_byte[36:29],
    // rx_byte[44:37], zero fill[47:45]
    input  logic [47:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_byte[7:0]
    output logic [7:0]  m_tdata,
    // action[4:0]
    output logic [4:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    plan_t push_plan;
    plan_t head_plan;
    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_empty;

    assign s_tready  = !queue_full;
    assign cfg_ready = 1'b1;

    i2cms_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_plan  (push_plan)
    );

    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_plan (push_plan),
        .pop       (pop),
        .head_plan (head_plan),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    i2cms_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_plan   (head_plan),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> design/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts input items, keeps the transfer state and turns each item into a
// plan of action slots for the back end.
// ----------------------------------------------------------------------------
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic [1:0]  s_tuser,
    input  logic [47:0] s_tdata,
    input  logic        queue_full,
    input  logic        cfg_valid,
    input  logic        cfg_data,
    output logic        push,
    output plan_t       push_plan
);

    logic [6:0]  target_address;
    logic [7:0]  transfer_length;
    logic        repeated_start;
    logic [7:0]  status_flags;
    logic [4:0]  error_flags;
    logic        accept;
    mode_t       mode;

    xfer_state_t state_reg, state_next;
    logic [6:0]  dev_addr_reg, dev_addr_next;
    logic [7:0]  rem_len_reg, rem_len_next;
    logic [7:0]  rx_size_reg, rx_size_next;
    logic        rpt_start_reg, rpt_start_next;
    logic        ev_irq_reg, ev_irq_next;
    logic        buf_irq_reg, buf_irq_next;
    logic        err_irq_reg, err_irq_next;
    logic        ack_ctrl_reg;

    assign target_address  = s_tdata[6:0];
    assign transfer_length = s_tdata[14:7];
    assign repeated_start  = s_tdata[15];
    assign status_flags    = s_tdata[23:16];
    assign error_flags     = s_tdata[28:24];
    assign mode            = mode_t'(s_tuser);

    assign accept = s_tvalid && !queue_full;
    assign push   = accept && (push_plan.mask != '0);

    always_comb begin
        xfer_state_t st_v;
        logic [7:0]  rem_v;
        logic        master;
        logic        transmitter;

        state_next     = state_reg;
        dev_addr_next  = dev_addr_reg;
        rem_len_next   = rem_len_reg;
        rx_size_next   = rx_size_reg;
        rpt_start_next = rpt_start_reg;
        ev_irq_next    = ev_irq_reg;
        buf_irq_next   = buf_irq_reg;
        err_irq_next   = err_irq_reg;

        push_plan.mask      = '0;
        push_plan.addr_byte = '0;
        push_plan.tx_byte   = s_tdata[36:29];
        push_plan.rx_byte   = s_tdata[44:37];

        st_v        = state_reg;
        rem_v       = rem_len_reg;
        master      = status_flags[6];
        transmitter = status_flags[7];

        case (mode)
            MODE_WRITE, MODE_READ: begin
                push_plan.addr_byte = {6'b0, state_reg};
                if (state_reg == ST_RX || state_reg == ST_TX) begin
                    push_plan.mask[SL_BUSY] = 1'b1;
                end else begin
                    push_plan.mask[SL_START] = 1'b1;
                    rem_len_next   = transfer_length;
                    dev_addr_next  = target_address;
                    rpt_start_next = repeated_start;
                    if (mode == MODE_READ) begin
                        state_next   = ST_RX;
                        rx_size_next = transfer_length;
                    end else begin
                        state_next = ST_TX;
                    end
                    ev_irq_next  = 1'b1;
                    buf_irq_next = 1'b1;
                    err_irq_next = 1'b1;
                end
            end
            MODE_EVENT: begin
                if (ev_irq_reg) begin
                    if (status_flags[0] && (st_v == ST_TX || st_v == ST_RX)) begin
                        push_plan.mask[SL_ADDR] = 1'b1;
                        push_plan.addr_byte = {dev_addr_reg, st_v == ST_RX};
                    end
                    if (status_flags[1]) begin
                        if (master && st_v == ST_RX && rx_size_reg == 8'd1)
                            push_plan.mask[SL_ACKOFF_A] = 1'b1;
                        push_plan.mask[SL_CLRADDR] = 1'b1;
                    end
                    // close a write once the last byte has left the shifter
                    if (status_flags[2] && st_v == ST_TX && status_flags[4] &&
                        rem_v == 8'd0) begin
                        push_plan.mask[SL_STOP_T] = !rpt_start_reg;
                        push_plan.mask[SL_TXDONE] = 1'b1;
                        buf_irq_next = 1'b0;
                        ev_irq_next  = 1'b0;
                        st_v         = ST_READY;
                        rem_v        = 8'd0;
                    end
                    if (status_flags[3])
                        push_plan.mask[SL_STOPF] = 1'b1;
                    if (buf_irq_reg && status_flags[4]) begin
                        if (master) begin
                            if (st_v == ST_TX && rem_v != 8'd0) begin
                                push_plan.mask[SL_WR] = 1'b1;
                                rem_v = rem_v - 8'd1;
                            end
                        end else if (transmitter) begin
                            push_plan.mask[SL_REQ] = 1'b1;
                        end
                    end
                    if (buf_irq_reg && status_flags[5]) begin
                        if (master) begin
                            if (st_v == ST_RX) begin
                                if (rx_size_reg > 8'd1 && rem_v == 8'd2)
                                    push_plan.mask[SL_ACKOFF_R] = 1'b1;
                                if (rx_size_reg != 8'd0) begin
                                    push_plan.mask[SL_RD] = 1'b1;
                                    rem_v = rem_v - 8'd1;
                                end
                                if (rem_v == 8'd0) begin
                                    push_plan.mask[SL_STOP_R] = !rpt_start_reg;
                                    push_plan.mask[SL_ACKON]  = ack_ctrl_reg;
                                    push_plan.mask[SL_RXDONE] = 1'b1;
                                    buf_irq_next = 1'b0;
                                    ev_irq_next  = 1'b0;
                                    st_v         = ST_READY;
                                    rx_size_next = 8'd0;
                                    rem_v        = 8'd0;
                                end
                            end
                        end else if (!transmitter) begin
                            push_plan.mask[SL_RCV] = 1'b1;
                        end
                    end
                    state_next   = st_v;
                    rem_len_next = rem_v;
                end
            end
            MODE_ERROR: begin
                if (err_irq_reg)
                    push_plan.mask[SL_ERR0 +: NUM_ERR] = error_flags;
            end
            default: begin
                push_plan.mask = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_READY;
            dev_addr_reg  <= '0;
            rem_len_reg   <= '0;
            rx_size_reg   <= '0;
            rpt_start_reg <= 1'b0;
            ev_irq_reg    <= 1'b0;
            buf_irq_reg   <= 1'b0;
            err_irq_reg   <= 1'b0;
            ack_ctrl_reg  <= 1'b1;
        end else begin
            if (accept) begin
                state_reg     <= state_next;
                dev_addr_reg  <= dev_addr_next;
                rem_len_reg   <= rem_len_next;
                rx_size_reg   <= rx_size_next;
                rpt_start_reg <= rpt_start_next;
                ev_irq_reg    <= ev_irq_next;
                buf_irq_reg   <= buf_irq_next;
                err_irq_reg   <= err_irq_next;
            end
            if (cfg_valid)
                ack_ctrl_reg <= cfg_data;
        end
    end

endmodule

>>> design/i2cms_queue.sv
// ----------------------------------------------------------------------------
// i2cms_queue
// Short first-in first-out queue of plans between front and back end.
// ----------------------------------------------------------------------------
module i2cms_queue
    import i2cms_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  plan_t push_plan,
    input  logic  pop,
    output plan_t head_plan,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    plan_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_plan = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_plan;
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("plan pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("plan popped from an empty queue");

endmodule

>>> design/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back
// Walks each plan slot by slot and emits one action beat per cycle, unless
// m_tready stalls it, through a registered output stage.
// ----------------------------------------------------------------------------
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  plan_t      head_plan,
    input  logic       queue_empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [4:0] m_tuser,
    output logic       m_tlast
);

    logic [NUM_SLOTS-1:0] cur_mask_reg, cur_mask_next;
    logic [7:0]           cur_addr_reg, cur_tx_reg, cur_rx_reg;
    logic                 out_valid_reg, out_valid_next;
    action_t              out_action_reg, out_action_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    logic                 advance;
    logic                 use_cur;
    logic                 have_work;
    logic [NUM_SLOTS-1:0] src_mask;
    logic [NUM_SLOTS-1:0] rest_mask;
    logic [7:0]           src_addr, src_tx, src_rx;
    logic [SLOT_W-1:0]    sel_slot;

    assign advance   = !out_valid_reg || m_tready;
    assign use_cur   = (cur_mask_reg != '0);
    assign have_work = use_cur || !queue_empty;
    assign pop       = advance && !use_cur && !queue_empty;

    assign src_mask  = use_cur ? cur_mask_reg : head_plan.mask;
    assign src_addr  = use_cur ? cur_addr_reg : head_plan.addr_byte;
    assign src_tx    = use_cur ? cur_tx_reg   : head_plan.tx_byte;
    assign src_rx    = use_cur ? cur_rx_reg   : head_plan.rx_byte;
    // drop the lowest pending slot
    assign rest_mask = src_mask & (src_mask - 1'b1);

    always_comb begin
        sel_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (src_mask[i])
                sel_slot = SLOT_W'(i);
        end
    end

    always_comb begin
        cur_mask_next   = cur_mask_reg;
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        if (advance) begin
            out_valid_next = have_work;
            if (have_work) begin
                cur_mask_next   = rest_mask;
                out_action_next = slot_action(sel_slot);
                out_last_next   = (rest_mask == '0);
                case (sel_slot)
                    SL_START, SL_BUSY, SL_ADDR: out_data_next = src_addr;
                    SL_WR:                      out_data_next = src_tx;
                    SL_RD:                      out_data_next = src_rx;
                    default:                    out_data_next = 8'd0;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_mask_reg  <= cur_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_action_reg <= out_action_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        if (pop) begin
            cur_addr_reg <= head_plan.addr_byte;
            cur_tx_reg   <= head_plan.tx_byte;
            cur_rx_reg   <= head_plan.rx_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_action_reg;
    assign m_tlast  = out_last_reg;

    // a partly walked plan always has a non-final beat on the output
    a_cur_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_mask_reg != '0) |-> (out_valid_reg && !out_last_reg))
        else $error("pending slots without a held non-final beat");

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cur_mask_reg == '0))
        else $error("new plan taken while slots still pending");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master interrupt sequencer. Start requests,
// status events and error items go in on the s_ stream. A cycle-level
// predictor of the transfer state machine turns each accepted item into the
// action beats it should cause. A monitor compares every m_ beat in order.
// Directed transfers come first, then randomized transfers with noise, a long
// read, and a long output stall. Both sides idle at random in most tests.
// ----------------------------------------------------------------------------
module tb;
    import i2cms_pkg::*;

    localparam int MAX_ACTIONS = 12;
    localparam int STALL_LIMIT = 2000;

    // Status flag bits of an event item
    localparam logic [7:0] SF_SB    = 8'h01;
    localparam logic [7:0] SF_ADDR  = 8'h02;
    localparam logic [7:0] SF_BTF   = 8'h04;
    localparam logic [7:0] SF_STOPF = 8'h08;
    localparam logic [7:0] SF_TXE   = 8'h10;
    localparam logic [7:0] SF_RXNE  = 8'h20;
    localparam logic [7:0] SF_MSL   = 8'h40;
    localparam logic [7:0] SF_TRA   = 8'h80;

    // Fields of one s_ beat; target_address sits in the low bits of tdata
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
        logic [4:0] error_flags;
        logic [7:0] status_flags;
        logic       repeated_start;
        logic [7:0] transfer_length;
        logic [6:0] target_address;
    } seq_item_t;

    typedef struct packed {
        action_t    act;
        logic [7:0] data;
        logic       last;
    } action_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    // Predicted sequencer state
    xfer_state_t seq_state     = ST_READY;
    logic [6:0]  seq_addr      = '0;
    logic [7:0]  seq_remaining = '0;
    logic [7:0]  seq_rx_size   = '0;
    logic        seq_repeat    = 1'b0;
    logic        seq_ev_on     = 1'b0;
    logic        seq_buf_on    = 1'b0;
    logic        seq_err_on    = 1'b0;
    logic        seq_ack_ctrl  = 1'b1;

    action_beat_t pending_actions[$];
    action_beat_t step_run[$];

    int err_count   = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int hold_cycles = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    always #1 aclk = ~aclk;

    i2c_master_interrupt_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic void push_action(action_t a, logic [7:0] d);
        if (step_run.size() < MAX_ACTIONS)
            step_run.push_back('{a, d, 1'b0});
    endfunction

    // Advance the predicted state by one item and queue the actions it causes
    function automatic void predict_actions(mode_t m, seq_item_t it);
        logic         ev_en;
        logic         buf_en;
        logic         master;
        logic         tra;
        logic [7:0]   sf;
        xfer_state_t  prior;
        action_beat_t beat;
        step_run.delete();
        sf     = it.status_flags;
        ev_en  = seq_ev_on;
        buf_en = seq_buf_on;
        master = sf[6];
        tra    = sf[7];
        case (m)
            MODE_WRITE, MODE_READ: begin
                prior = seq_state;
                if (prior == ST_RX || prior == ST_TX) begin
                    push_action(A_BUSY, {6'b0, prior});
                end else begin
                    seq_remaining = it.transfer_length;
                    seq_addr      = it.target_address;
                    seq_repeat    = it.repeated_start;
                    if (m == MODE_READ) begin
                        seq_state   = ST_RX;
                        seq_rx_size = it.transfer_length;
                    end else begin
                        seq_state = ST_TX;
                    end
                    seq_ev_on  = 1'b1;
                    seq_buf_on = 1'b1;
                    seq_err_on = 1'b1;
                    push_action(A_START, {6'b0, prior});
                end
            end
            MODE_EVENT: begin
                if (ev_en) begin
                    if (sf[0]) begin
                        if (seq_state == ST_TX)
                            push_action(A_ADDR, {seq_addr, 1'b0});
                        else if (seq_state == ST_RX)
                            push_action(A_ADDR, {seq_addr, 1'b1});
                    end
                    if (sf[1]) begin
                        if (master && seq_state == ST_RX && seq_rx_size == 8'd1)
                            push_action(A_ACKOFF, 8'h00);
                        push_action(A_CLRADDR, 8'h00);
                    end
                    if (sf[2] && sf[4] && seq_state == ST_TX && seq_remaining == 8'd0) begin
                        if (!seq_repeat)
                            push_action(A_STOP, 8'h00);
                        seq_buf_on    = 1'b0;
                        seq_ev_on     = 1'b0;
                        seq_state     = ST_READY;
                        seq_remaining = 8'd0;
                        push_action(A_TXDONE, 8'h00);
                    end
                    if (sf[3])
                        push_action(A_STOPF, 8'h00);
                    // handlers below use the enables sampled on entry
                    if (buf_en && sf[4]) begin
                        if (master) begin
                            if (seq_state == ST_TX && seq_remaining != 8'd0) begin
                                push_action(A_WR, it.tx_byte);
                                seq_remaining = seq_remaining - 8'd1;
                            end
                        end else if (tra) begin
                            push_action(A_REQ, 8'h00);
                        end
                    end
                    if (buf_en && sf[5]) begin
                        if (master) begin
                            if (seq_state == ST_RX) begin
                                if (seq_rx_size == 8'd1) begin
                                    push_action(A_RD, it.rx_byte);
                                    seq_remaining = seq_remaining - 8'd1;
                                end
                                if (seq_rx_size > 8'd1) begin
                                    if (seq_remaining == 8'd2)
                                        push_action(A_ACKOFF, 8'h00);
                                    push_action(A_RD, it.rx_byte);
                                    seq_remaining = seq_remaining - 8'd1;
                                end
                                if (seq_remaining == 8'd0) begin
                                    if (!seq_repeat)
                                        push_action(A_STOP, 8'h00);
                                    seq_buf_on    = 1'b0;
                                    seq_ev_on     = 1'b0;
                                    seq_state     = ST_READY;
                                    seq_rx_size   = 8'd0;
                                    seq_remaining = 8'd0;
                                    if (seq_ack_ctrl)
                                        push_action(A_ACKON, 8'h00);
                                    push_action(A_RXDONE, 8'h00);
                                end
                            end
                        end else if (!tra) begin
                            push_action(A_RCV, 8'h00);
                        end
                    end
                end
            end
            default: begin
                if (seq_err_on) begin
                    for (int i = 0; i < NUM_ERR; i++)
                        if (it.error_flags[i])
                            push_action(action_t'(int'(A_ERR_BUS) + i), 8'h00);
                end
            end
        endcase
        foreach (step_run[i]) begin
            beat      = step_run[i];
            beat.last = (i == step_run.size() - 1);
            pending_actions.push_back(beat);
        end
    endfunction

    // Predict on input beats first, then check the output beat of the same edge
    always @(posedge aclk) begin
        action_beat_t want;
        bit           progress;
        progress = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_actions(mode_t'(s_tuser), s_tdata[44:0]);
                items_sent++;
                progress = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                seq_ack_ctrl = cfg_data;
                progress = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                progress = 1'b1;
                if (pending_actions.size() == 0) begin
                    report_mismatch("beat with nothing pending, action", m_tuser, -1);
                end else begin
                    want = pending_actions.pop_front();
                    if (m_tuser != want.act)
                        report_mismatch("action", m_tuser, want.act);
                    if (m_tdata != want.data)
                        report_mismatch("data_byte", m_tdata, want.data);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold when a test asks for one
    initial begin
        int r;
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                r = $urandom_range(0, 99);
                if (stalls_on && r < 25)
                    stall_left = (r < 3) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic seq_item_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[44:0];
    endfunction

    // Called and returns at a falling edge; valid stays up when no gap follows
    task automatic send_item(mode_t m, seq_item_t it);
        int gap;
        s_tuser  = m;
        s_tdata  = {3'b000, it};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_start(mode_t m, logic [6:0] addr, logic [7:0] len, logic rs);
        seq_item_t it;
        it                 = random_item();
        it.target_address  = addr;
        it.transfer_length = len;
        it.repeated_start  = rs;
        send_item(m, it);
    endtask

    task automatic send_event(logic [7:0] sf, logic [7:0] txb, logic [7:0] rxb);
        seq_item_t it;
        it              = random_item();
        it.status_flags = sf;
        it.tx_byte      = txb;
        it.rx_byte      = rxb;
        send_item(MODE_EVENT, it);
    endtask

    task automatic send_noise();
        seq_item_t it;
        int        r;
        it = random_item();
        r  = $urandom_range(0, 99);
        if (r < 50) begin
            send_item(MODE_EVENT, it);
        end else if (r < 85) begin
            send_item(MODE_ERROR, it);
        end else begin
            // keep accepted starts short so the transfer closes soon
            if (seq_state == ST_READY)
                it.transfer_length = 8'($urandom_range(0, 7));
            send_item((r < 92) ? MODE_WRITE : MODE_READ, it);
        end
    endtask

    // Drop valid, drain every pending action, then allow the queue to empty
    task automatic wait_idle();
        s_tvalid = 1'b0;
        wait (pending_actions.size() == 0);
        repeat (16) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_ack_control(logic v);
        wait_idle();
        cfg_data  = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // One well-formed transfer with random content, closed by following the
    // predicted state; noise is mixed in. Negative arguments pick at random.
    task automatic run_transfer(int len_sel, int dir_sel);
        int         len;
        int         guard;
        bit         rd;
        logic [7:0] sf_dir;
        rd = (dir_sel < 0) ? 1'($urandom_range(0, 1)) : 1'(dir_sel);
        if (len_sel >= 0) begin
            len = len_sel;
        end else begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4) : $urandom_range(5, 20);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
        end
        if (seq_state == ST_READY)
            send_start(rd ? MODE_READ : MODE_WRITE, 7'($urandom_range(0, 127)), 8'(len),
                       1'($urandom_range(0, 1)));
        sf_dir = (seq_state == ST_TX) ? SF_TRA : 8'h00;
        send_event(SF_SB | SF_MSL | sf_dir, 8'($urandom), 8'($urandom));
        send_event(SF_ADDR | SF_MSL | sf_dir, 8'($urandom), 8'($urandom));
        guard = 0;
        while ((seq_state == ST_RX || seq_state == ST_TX) && guard < 400) begin
            guard++;
            if ($urandom_range(0, 99) < 10)
                send_noise();
            else if (seq_state == ST_TX)
                send_event(SF_MSL | SF_TRA | SF_TXE | ((seq_remaining == 0) ? SF_BTF : 8'h00),
                           8'($urandom), 8'($urandom));
            else
                send_event(SF_MSL | SF_RXNE, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_ignored_before_start();
        seq_item_t it;
        // no interrupt enabled yet: neither item may produce a beat
        it             = random_item();
        it.error_flags = 5'h1F;
        send_item(MODE_ERROR, it);
        send_event(8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_write_transfer();
        seq_item_t it;
        send_start(MODE_WRITE, 7'h7F, 8'd2, 1'b0);
        send_start(MODE_READ, 7'h00, 8'd255, 1'b1);
        send_event(SF_SB | SF_MSL | SF_TRA, 8'h00, 8'h00);
        send_event(SF_ADDR | SF_MSL | SF_TRA, 8'h00, 8'h00);
        send_event(SF_TXE | SF_MSL | SF_TRA, 8'hFF, 8'h00);
        send_event(SF_TXE | SF_MSL | SF_TRA, 8'h00, 8'hFF);
        send_event(SF_BTF | SF_TXE | SF_MSL | SF_TRA, 8'hA5, 8'h5A);
        // error interrupts stay enabled after the transfer closes
        it             = random_item();
        it.error_flags = 5'h1F;
        send_item(MODE_ERROR, it);
    endtask

    task automatic test_read_transfer();
        // one-byte read: ACK off precedes the address clear; no stop
        send_start(MODE_READ, 7'h00, 8'd1, 1'b1);
        send_event(SF_SB | SF_MSL, 8'h00, 8'h00);
        send_event(SF_ADDR | SF_MSL, 8'h00, 8'h00);
        send_event(SF_RXNE | SF_MSL, 8'h00, 8'hFF);
        set_ack_control(1'b0);
        // three bytes: ACK off before the last one, no ACK re-enable
        send_start(MODE_READ, 7'h55, 8'd3, 1'b0);
        send_event(SF_RXNE | SF_MSL, 8'h00, 8'h01);
        send_event(SF_RXNE | SF_MSL, 8'h00, 8'h80);
        send_event(SF_RXNE | SF_MSL, 8'h00, 8'h00);
        // zero bytes: the first receive notice closes without a read
        send_start(MODE_READ, 7'h2A, 8'd0, 1'b0);
        send_event(SF_RXNE | SF_MSL, 8'h00, 8'h33);
    endtask

    task automatic test_slave_notices();
        send_start(MODE_WRITE, 7'h41, 8'd0, 1'b0);
        send_event(SF_TRA | SF_TXE | SF_STOPF, 8'h00, 8'h00);
        send_event(SF_RXNE, 8'h00, 8'h00);
        send_event(SF_SB | SF_ADDR, 8'h00, 8'h00);
        send_event(SF_BTF | SF_TXE | SF_MSL | SF_TRA, 8'h00, 8'h00);
    endtask

    task automatic test_random_traffic(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_noise();
            else
                run_transfer(-1, -1);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_long_read();
        run_transfer(60, 1);
    endtask

    task automatic test_output_stall();
        wait_idle();
        // hold the output while items keep coming, so the block backs up
        gaps_on     = 1'b0;
        hold_cycles = 300;
        run_transfer(12, 0);
        gaps_on = 1'b1;
        // pause the sender until every pending action has arrived
        wait_idle();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_WRITE;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_ignored_before_start();
        test_write_transfer();
        test_read_transfer();
        test_slave_notices();
        test_random_traffic(55);
        set_ack_control(1'b1);
        test_random_traffic(55);
        test_long_read();
        test_output_stall();
        set_ack_control(1'b0);
        test_random_traffic(30);
        set_ack_control(1'b1);
        test_random_traffic(30);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
